// File: hw/rtl/incremental_mst_weight_macros.svh
// Assertion macros shared by the incremental spanning tree weight block.
`ifndef INCREMENTAL_MST_WEIGHT_MACROS_SVH
`define INCREMENTAL_MST_WEIGHT_MACROS_SVH

// Same-cycle implication, reset masked.
`define IMW_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset masked.
`define IMW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/imw_pkg.sv
// Shared constants of the incremental spanning tree weight block.
package imw_pkg;
	localparam int NODE_BITS       = 9;
	localparam int IN_WEIGHT_BITS  = 16;
	localparam int TREE_BITS       = 24;
	localparam logic [TREE_BITS-1:0] TREE_MAX = 24'hFF_FFFF;
	localparam int DEF_MAX_NODES   = 256;
	localparam int DEF_WEIGHT_BITS = 16;
	localparam logic [NODE_BITS-1:0] NODE_COUNT_RST = 9'd256;
endpackage

// File: hw/rtl/incremental_mst_weight.sv
// Incremental MST weight block: Kruskal rerun over the kept forest for every new edge.
// Each new edge starts a pass: the parent table is initialised, then stored and new candidates
// are taken in weight order, each in-range one run through find and path compression on both
// root paths before the join; a new edge is taken only once busy has dropped.
// Busy drops in the done cycle; receiver cannot stall.
// Async active-low reset empties the edge store and sets node_count to 256; no clearing pass.
`include "incremental_mst_weight_macros.svh"
module incremental_mst_weight #(
	parameter int MAX_NODES   = imw_pkg::DEF_MAX_NODES,
	parameter int WEIGHT_BITS = imw_pkg::DEF_WEIGHT_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [imw_pkg::NODE_BITS-1:0]       end_a,
	input  logic [imw_pkg::NODE_BITS-1:0]       end_b,
	input  logic [imw_pkg::IN_WEIGHT_BITS-1:0]  edge_weight,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [imw_pkg::NODE_BITS-1:0]       cfg_data,
	output logic                                done,
	output logic [imw_pkg::TREE_BITS-1:0]       tree_weight,
	output logic                                connected
);
	localparam int NB   = imw_pkg::NODE_BITS;
	localparam int AW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int TW   = $clog2(MAX_NODES + 1);
	localparam int EW   = 2 * NB + WEIGHT_BITS;
	localparam int SUMW = ((WEIGHT_BITS > imw_pkg::TREE_BITS) ? WEIGHT_BITS
		: imw_pkg::TREE_BITS) + 1;
	localparam int DEPTH = 2 * MAX_NODES;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_INIT = 4'd1;
	localparam logic [3:0] ST_RD   = 4'd2;
	localparam logic [3:0] ST_PICK = 4'd3;
	localparam logic [3:0] ST_FRD  = 4'd4;
	localparam logic [3:0] ST_FCK  = 4'd5;
	localparam logic [3:0] ST_CRD  = 4'd6;
	localparam logic [3:0] ST_CWR  = 4'd7;
	localparam logic [3:0] ST_JOIN = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	// storage: two banks of edges (ping-pong), one parent table
	logic [EW-1:0] edge_mem [DEPTH];
	logic [NB-1:0] par_mem  [MAX_NODES];

	logic [3:0]             state_q;
	logic [NB-1:0]          node_count_q;
	logic [TW-1:0]          total_q, lim_q, rp_q, keep_q;
	logic                   bank_q, ins_pend_q, side_q;
	logic [NB-1:0]          a_q, b_q, ca_q, cb_q, x_q, r_q, ra_q, ki_q;
	logic [WEIGHT_BITS-1:0] w_q, cw_q;
	logic [imw_pkg::TREE_BITS-1:0] sum_q;
	logic [EW-1:0]          edge_rd_q;
	logic [NB-1:0]          par_rd_q;
	logic                   done_q, conn_q;
	logic [imw_pkg::TREE_BITS-1:0] tree_q;

	logic [NB-1:0]          n;
	logic                   a_ok, b_ok, use_new, cand_ok;
	logic [NB-1:0]          rd_a, rd_b, nx_a, nx_b;
	logic [WEIGHT_BITS-1:0] rd_w, nx_w, w_in;
	logic                   par_we;
	logic [AW-1:0]          par_waddr, par_raddr;
	logic [NB-1:0]          par_wdata;
	logic                   edge_we;
	logic [AW:0]            edge_waddr, edge_raddr;
	logic [SUMW-1:0]        sum_next;
	logic                   conn_now;

	// effective node count
	assign n = (32'(node_count_q) > MAX_NODES) ? NB'(MAX_NODES) : node_count_q;
	assign w_in = WEIGHT_BITS'(edge_weight);
	assign a_ok = (end_a != '0) && (end_a <= n);
	assign b_ok = (end_b != '0) && (end_b <= n);

	// config waits while busy or while an edge word is offered on start
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy & ~start;
	assign done        = done_q;
	assign tree_weight = tree_q;
	assign connected   = conn_q;

	// candidate selection: new edge goes ahead of stored edges of equal weight
	assign {rd_a, rd_b, rd_w} = edge_rd_q;
	assign use_new = ins_pend_q && ((rp_q == lim_q) || (rd_w >= w_q));
	assign nx_a = use_new ? a_q : rd_a;
	assign nx_b = use_new ? b_q : rd_b;
	assign nx_w = use_new ? w_q : rd_w;
	assign cand_ok = (nx_a != '0) && (nx_a <= n) && (nx_b != '0) && (nx_b <= n);

	assign sum_next = SUMW'(sum_q) + SUMW'(cw_q);
	assign conn_now = (n != '0) && (32'(keep_q) == 32'(n) - 32'd1);

	// memory addressing
	always_comb begin
		par_we     = 1'b0;
		par_waddr  = AW'(x_q - NB'(1));
		par_wdata  = r_q;
		par_raddr  = AW'(x_q - NB'(1));
		edge_we    = 1'b0;
		edge_waddr = {~bank_q, AW'(keep_q)};
		edge_raddr = {bank_q, AW'(rp_q)};
		unique case (state_q)
			ST_INIT: begin
				par_we    = (ki_q != n);
				par_waddr = AW'(ki_q);
				par_wdata = ki_q + NB'(1);
			end
			ST_CWR: par_we = 1'b1;
			ST_JOIN: begin
				par_we    = (ra_q != r_q);
				par_waddr = AW'(ra_q - NB'(1));
				edge_we   = (ra_q != r_q);
			end
			default: ;
		endcase
	end

	// memories
	always_ff @(posedge clk) begin
		if (par_we) begin
			par_mem[par_waddr] <= par_wdata;
		end
		par_rd_q <= par_mem[par_raddr];
		if (edge_we) begin
			edge_mem[edge_waddr] <= {ca_q, cb_q, cw_q};
		end
		edge_rd_q <= edge_mem[edge_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= imw_pkg::NODE_COUNT_RST;
			total_q      <= '0;
			bank_q       <= 1'b0;
			ins_pend_q   <= 1'b0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						a_q        <= end_a;
						b_q        <= end_b;
						w_q        <= w_in;
						ins_pend_q <= a_ok && b_ok;
						lim_q      <= (a_ok && b_ok && 32'(total_q) >= MAX_NODES)
							? TW'(MAX_NODES - 1) : total_q;
						rp_q       <= '0;
						keep_q     <= '0;
						sum_q      <= '0;
						ki_q       <= '0;
						state_q    <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (ki_q == n) begin
						state_q <= ST_RD;
					end else begin
						ki_q <= ki_q + NB'(1);
					end
				end
				ST_RD: begin
					state_q <= (!ins_pend_q && rp_q == lim_q) ? ST_DONE : ST_PICK;
				end
				ST_PICK: begin
					ca_q <= nx_a;
					cb_q <= nx_b;
					cw_q <= nx_w;
					if (use_new) begin
						ins_pend_q <= 1'b0;
					end else begin
						rp_q <= rp_q + TW'(1);
					end
					x_q     <= nx_a;
					side_q  <= 1'b0;
					state_q <= cand_ok ? ST_FRD : ST_RD;
				end
				ST_FRD: state_q <= ST_FCK;
				ST_FCK: begin
					if (par_rd_q == x_q) begin
						r_q     <= x_q;
						x_q     <= side_q ? cb_q : ca_q;
						state_q <= ST_CRD;
					end else begin
						x_q     <= par_rd_q;
						state_q <= ST_FRD;
					end
				end
				ST_CRD: begin
					if (x_q == r_q) begin
						if (!side_q) begin
							ra_q    <= r_q;
							side_q  <= 1'b1;
							x_q     <= cb_q;
							state_q <= ST_FRD;
						end else begin
							state_q <= ST_JOIN;
						end
					end else begin
						state_q <= ST_CWR;
					end
				end
				ST_CWR: begin
					x_q     <= par_rd_q;
					state_q <= ST_CRD;
				end
				ST_JOIN: begin
					if (ra_q != r_q) begin
						keep_q <= keep_q + TW'(1);
						sum_q  <= (sum_next > SUMW'(imw_pkg::TREE_MAX))
							? imw_pkg::TREE_MAX : sum_next[imw_pkg::TREE_BITS-1:0];
					end
					state_q <= ST_RD;
				end
				ST_DONE: begin
					total_q <= keep_q;
					bank_q  <= ~bank_q;
					done_q  <= 1'b1;
					conn_q  <= conn_now;
					tree_q  <= conn_now ? sum_q : '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	`IMW_ASSERT_IMPL(a_done_idle, done, !busy, "done strobe while busy")
	`IMW_ASSERT_IMPL(a_zero_open, done && !connected, tree_weight == '0, "weight on open graph")
	`IMW_ASSERT_IMPL(a_rp_bound, busy, rp_q <= lim_q, "read pointer past stored count")
	`IMW_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted word not taken")
endmodule

// File: tb/incremental_mst_weight_checker.sv
// Checker for the incremental spanning tree weight block: predicts and compares every word.
module incremental_mst_weight_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               busy,
	input  logic [imw_pkg::NODE_BITS-1:0]      end_a,
	input  logic [imw_pkg::NODE_BITS-1:0]      end_b,
	input  logic [imw_pkg::IN_WEIGHT_BITS-1:0] edge_weight,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [imw_pkg::NODE_BITS-1:0]      cfg_data,
	input  logic                               done,
	input  logic [imw_pkg::TREE_BITS-1:0]      tree_weight,
	input  logic                               connected,
	output int                                 errors,
	output int                                 pending,
	output int                                 spans_checked,
	output int                                 spans_connected
);
	localparam int MAXN = imw_pkg::DEF_MAX_NODES;

	typedef struct packed {
		logic [imw_pkg::TREE_BITS-1:0] weight;
		logic                          conn;
	} span_t;

	// forest edges kept sorted by weight, plus the union-find table
	logic [imw_pkg::NODE_BITS-1:0]      forest_a [MAXN];
	logic [imw_pkg::NODE_BITS-1:0]      forest_b [MAXN];
	logic [imw_pkg::IN_WEIGHT_BITS-1:0] forest_w [MAXN];
	int                                 forest_len;
	int                                 parent [MAXN+1];
	logic [imw_pkg::NODE_BITS-1:0]      node_count;
	span_t                              span_q [$];

	function automatic int find_root(int x);
		int r;
		int up;
		r = x;
		while (parent[r] != r) r = parent[r];
		while (x != r) begin
			up = parent[x];
			parent[x] = r;
			x = up;
		end
		return r;
	endfunction

	// insert the new edge, rerun Kruskal, keep the forest, return the span
	function automatic span_t insert_and_span(int a, int b, int w);
		int n;
		int pos;
		int keep;
		int joined;
		int ra;
		int rb;
		longint sum;
		span_t s;
		n = (node_count > MAXN) ? MAXN : int'(node_count);
		if (a >= 1 && a <= n && b >= 1 && b <= n) begin
			if (forest_len >= MAXN) forest_len = MAXN - 1;
			pos = 0;
			while (pos < forest_len && forest_w[pos] < w) pos++;
			for (int i = forest_len; i > pos; i--) begin
				forest_a[i] = forest_a[i-1];
				forest_b[i] = forest_b[i-1];
				forest_w[i] = forest_w[i-1];
			end
			forest_a[pos] = imw_pkg::NODE_BITS'(a);
			forest_b[pos] = imw_pkg::NODE_BITS'(b);
			forest_w[pos] = imw_pkg::IN_WEIGHT_BITS'(w);
			forest_len++;
		end
		for (int i = 0; i <= n; i++) parent[i] = i;
		keep = 0;
		joined = 0;
		sum = 0;
		for (int i = 0; i < forest_len; i++) begin
			if (forest_a[i] < 1 || forest_a[i] > n || forest_b[i] < 1 || forest_b[i] > n)
				continue;
			ra = find_root(int'(forest_a[i]));
			rb = find_root(int'(forest_b[i]));
			if (ra == rb) continue;
			parent[ra] = rb;
			forest_a[keep] = forest_a[i];
			forest_b[keep] = forest_b[i];
			forest_w[keep] = forest_w[i];
			sum += forest_w[i];
			keep++;
			joined++;
		end
		forest_len = keep;
		if (sum > imw_pkg::TREE_MAX) sum = imw_pkg::TREE_MAX;
		s.conn = (n >= 1) && (joined == n - 1);
		s.weight = s.conn ? imw_pkg::TREE_BITS'(sum) : '0;
		return s;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d expected %0d (span %0d)", what, got, want,
			spans_checked);
		errors++;
	endtask

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		span_t want;
		if (!arst_n) begin
			forest_len = 0;
			node_count = imw_pkg::NODE_COUNT_RST;
			span_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) node_count = cfg_data;
			if (done) begin
				if (span_q.size() == 0) begin
					report("result word with nothing expected", 1, 0);
				end else begin
					want = span_q.pop_front();
					if (tree_weight !== want.weight)
						report("tree_weight", int'(tree_weight), int'(want.weight));
					if (connected !== want.conn)
						report("connected", int'(connected), int'(want.conn));
					spans_connected += int'(want.conn);
				end
				spans_checked++;
			end
			if (start && !busy)
				span_q.insert(span_q.size(), insert_and_span(end_a, end_b, edge_weight));
		end
	end

	assign pending = span_q.size();

	initial begin
		errors = 0;
		spans_checked = 0;
		spans_connected = 0;
	end
endmodule

// File: tb/incremental_mst_weight_test.sv
// Testbench top for the incremental spanning tree weight block: stimulus and verdict.
module incremental_mst_weight_test;
	localparam int IDLE_LIMIT = 200000;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic [imw_pkg::NODE_BITS-1:0]       end_a;
	logic [imw_pkg::NODE_BITS-1:0]       end_b;
	logic [imw_pkg::IN_WEIGHT_BITS-1:0]  edge_weight;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [imw_pkg::NODE_BITS-1:0]       cfg_data;
	logic                                done;
	logic [imw_pkg::TREE_BITS-1:0]       tree_weight;
	logic                                connected;
	int                                  errors;
	int                                  pending;
	int                                  spans_checked;
	int                                  spans_connected;
	int                                  edges_sent;
	int                                  phases;
	int                                  idle_cycles;
	int                                  cur_n;

	incremental_mst_weight dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.end_a(end_a), .end_b(end_b), .edge_weight(edge_weight),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .tree_weight(tree_weight), .connected(connected)
	);

	incremental_mst_weight_checker span_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.end_a(end_a), .end_b(end_b), .edge_weight(edge_weight),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.done(done), .tree_weight(tree_weight), .connected(connected),
		.errors(errors), .pending(pending), .spans_checked(spans_checked),
		.spans_connected(spans_connected)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// watchdog: cycles with no word accepted on any channel
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// hold one edge word until the block takes it; start stays high on return
	task automatic send_edge(input int a, input int b, input int w);
		start <= 1'b1;
		end_a <= imw_pkg::NODE_BITS'(a);
		end_b <= imw_pkg::NODE_BITS'(b);
		edge_weight <= imw_pkg::IN_WEIGHT_BITS'(w);
		@(posedge clk);
		while (busy) @(posedge clk);
		edges_sent++;
	endtask

	// lower start and wait for every expected span, then let the block settle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_nodes(input int n);
		cfg_valid <= 1'b1;
		cfg_data <= imw_pkg::NODE_BITS'(n);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_n = n;
		phases++;
	endtask

	function automatic int pick_node();
		int lim;
		lim = (cur_n > imw_pkg::DEF_MAX_NODES) ? imw_pkg::DEF_MAX_NODES : cur_n;
		if (lim < 1 || $urandom_range(0, 9) == 0) return $urandom_range(0, 511);
		return $urandom_range(1, lim);
	endfunction

	function automatic int pick_weight();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 16'hFFFF;
			2: return $urandom_range(0, 15);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	initial begin
		int count;
		int burst;
		start = 1'b0;
		end_a = '0;
		end_b = '0;
		edge_weight = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_cycles = 0;
		edges_sent = 0;
		phases = 0;
		cur_n = 256;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset node count, extremes, out of range endpoints, self loop
		send_edge(1, 256, 16'hFFFF);
		send_edge(0, 5, 7);
		send_edge(257, 3, 7);
		send_edge(511, 511, 0);
		send_edge(256, 256, 3);
		drain();
		// one node: always spanning with zero weight
		write_nodes(1);
		send_edge(1, 1, 16'hFFFF);
		send_edge(2, 1, 5);
		drain();
		// zero nodes: nothing in range, never spanning
		write_nodes(0);
		send_edge(1, 1, 1);
		send_edge(0, 0, 0);
		drain();
		// four nodes: build a tree, then a cheaper redundant edge replaces one
		write_nodes(4);
		send_edge(1, 2, 16'hFFFF);
		send_edge(2, 3, 16'hFFFF);
		send_edge(3, 4, 16'hFFFF);
		send_edge(1, 3, 10);
		send_edge(4, 1, 10);
		send_edge(2, 4, 10);
		drain();
		// lower the count so stored edges fall out of range, then count above the store
		write_nodes(3);
		send_edge(1, 3, 2);
		drain();
		write_nodes(511);
		send_edge(1, 255, 9);
		drain();

		// random phases: mostly small graphs, bursts with gaps between
		while (edges_sent < 290) begin
			case ($urandom_range(0, 9))
				0: write_nodes($urandom_range(0, 1));
				1: write_nodes(256);
				2: write_nodes($urandom_range(257, 511));
				default: write_nodes($urandom_range(2, 12));
			endcase
			count = $urandom_range(10, 30);
			while (count > 0) begin
				burst = $urandom_range(1, 8);
				while (burst > 0 && count > 0) begin
					send_edge(pick_node(), pick_node(), pick_weight());
					burst--;
					count--;
				end
				if ($urandom_range(0, 2) != 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 20)) @(posedge clk);
				end
			end
			drain();
		end

		repeat (20) @(posedge clk);
		$display("Covered %0d edges over %0d node count settings; %0d spans checked,",
			edges_sent, phases, spans_checked);
		$display("%0d of them connected.", spans_connected);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
